[src/dsbe_pkg.sv]
// ----------------------------------------------------------------------------
// dsbe_pkg
// Shared constants, types and register codes of the eye-distance depth sorter.
// ----------------------------------------------------------------------------
package dsbe_pkg;

    localparam int MAX_POINTS = 64;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int COORD_W    = 16;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int KEY_W      = 34;
    localparam int POINT_W    = 3 * COORD_W;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_EYE_X          = 2'd0;
    localparam reg_idx_t REG_EYE_Y          = 2'd1;
    localparam reg_idx_t REG_EYE_Z          = 2'd2;
    localparam reg_idx_t REG_FARTHEST_FIRST = 2'd3;

    typedef enum logic
    {
        ST_FILL,
        ST_EMIT
    } state_t;

    // Broadcast from the controller to every cell of the chain.
    typedef struct packed
    {
        logic insert;
        logic emit;
        logic farthest_first;
    } cell_ctrl_t;

    // A point with its finished key, as it leaves the key pipeline.
    typedef struct packed
    {
        logic               valid;
        logic               set_end;
        logic [POINT_W-1:0] point;
        logic [KEY_W-1:0]   key;
    } key_item_t;

endpackage

[src/dsbe_key.sv]
// ----------------------------------------------------------------------------
// dsbe_key
// Two-stage pipeline that computes the squared distance of a point to the eye.
// ----------------------------------------------------------------------------
module dsbe_key
    import dsbe_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic signed [COORD_W-1:0] point_x,
    input  logic signed [COORD_W-1:0] point_y,
    input  logic signed [COORD_W-1:0] point_z,
    input  logic                      set_end,
    input  logic signed [COORD_W-1:0] eye_x,
    input  logic signed [COORD_W-1:0] eye_y,
    input  logic signed [COORD_W-1:0] eye_z,
    output key_item_t                 item,
    output logic                      busy_end
);

    logic signed [DIFF_W-1:0]   dx;
    logic signed [DIFF_W-1:0]   dy;
    logic signed [DIFF_W-1:0]   dz;
    logic signed [2*DIFF_W-1:0] px;
    logic signed [2*DIFF_W-1:0] py;
    logic signed [2*DIFF_W-1:0] pz;

    logic [SQ_W-1:0]    sqx_reg;
    logic [SQ_W-1:0]    sqy_reg;
    logic [SQ_W-1:0]    sqz_reg;
    logic [POINT_W-1:0] s1_point_reg;
    logic               s1_valid_reg;
    logic               s1_end_reg;
    logic               s2_valid_reg;
    logic               s2_end_reg;
    logic [POINT_W-1:0] s2_point_reg;
    logic [KEY_W-1:0]   s2_key_reg;
    logic [KEY_W-1:0]   sum;

    always_comb
    begin
        dx = DIFF_W'(point_x) - DIFF_W'(eye_x);
        dy = DIFF_W'(point_y) - DIFF_W'(eye_y);
        dz = DIFF_W'(point_z) - DIFF_W'(eye_z);
        px = dx * dx;
        py = dy * dy;
        pz = dz * dz;
        sum = KEY_W'(sqx_reg) + KEY_W'(sqy_reg) + KEY_W'(sqz_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_end_reg   <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_end_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s1_end_reg   <= accept && set_end;
            s2_valid_reg <= s1_valid_reg;
            s2_end_reg   <= s1_end_reg;
        end
    end

    // The square of a 17-bit difference always fits in 32 bits.
    always_ff @(posedge clk)
    begin
        sqx_reg      <= px[SQ_W-1:0];
        sqy_reg      <= py[SQ_W-1:0];
        sqz_reg      <= pz[SQ_W-1:0];
        s1_point_reg <= {point_z, point_y, point_x};
        s2_point_reg <= s1_point_reg;
        s2_key_reg   <= sum;
    end

    always_comb
    begin
        item.valid   = s2_valid_reg;
        item.set_end = s2_end_reg;
        item.point   = s2_point_reg;
        item.key     = s2_key_reg;
    end

    assign busy_end = s1_end_reg || s2_end_reg;

endmodule

[src/dsbe_cell.sv]
// ----------------------------------------------------------------------------
// dsbe_cell
// One compare-and-shift cell of the sorted chain.
// ----------------------------------------------------------------------------
module dsbe_cell
    import dsbe_pkg::*;
(
    input  logic               clk,
    input  cell_ctrl_t         ctrl,
    input  logic               free,
    input  logic [KEY_W-1:0]   new_key,
    input  logic [POINT_W-1:0] new_point,
    input  logic [KEY_W-1:0]   prev_key,
    input  logic [POINT_W-1:0] prev_point,
    input  logic [KEY_W-1:0]   next_key,
    input  logic [POINT_W-1:0] next_point,
    input  logic               taken_in,
    output logic               taken_out,
    output logic [KEY_W-1:0]   key,
    output logic [POINT_W-1:0] point
);

    logic [KEY_W-1:0]   key_reg;
    logic [KEY_W-1:0]   key_next;
    logic [POINT_W-1:0] point_reg;
    logic [POINT_W-1:0] point_next;
    logic               passes;
    logic               here;

    always_comb
    begin
        passes = ctrl.farthest_first ? (key_reg < new_key) : (key_reg > new_key);
        here   = free || passes;
        key_next   = key_reg;
        point_next = point_reg;
        if (ctrl.insert)
        begin
            // Once an earlier cell has taken the new point, everything after it
            // moves one place down the chain.
            if (taken_in)
            begin
                key_next   = prev_key;
                point_next = prev_point;
            end
            else if (here)
            begin
                key_next   = new_key;
                point_next = new_point;
            end
        end
        else if (ctrl.emit)
        begin
            key_next   = next_key;
            point_next = next_point;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        point_reg <= point_next;
    end

    assign taken_out = taken_in || here;
    assign key       = key_reg;
    assign point     = point_reg;

endmodule

[src/depth_sort_points_by_eye_distance.sv]
// ----------------------------------------------------------------------------
// depth_sort_points_by_eye_distance
// Stable insertion sort of 3D points by squared distance to an eye point.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake                | Payload
//  ---------+--------------------------+------------------------------------------
//  point    | point_valid, point_stall | point_x, point_y, point_z, set_end
//  sorted   | sorted_valid,sorted_stall| sorted_x/y/z, final_point, overflowed
//  config   | APB write/read           | eye_x, eye_y, eye_z, farthest_first
//
//  While a set is filling, one point request is taken every cycle; each enters the
//  cell chain after the square registers and the key register of the squared-distance pipeline.
//  A request with set_end holds off new points until its set has left the cell chain;
//  the held points come out of the head cell one per cycle while the sorted channel does not stall.
//  Reset clears the control state and the configuration registers; the cell chain needs no clearing.
//  A stall on the sorted channel holds the emit sequence in place.
//
module depth_sort_points_by_eye_distance
    import dsbe_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready,
    input  logic                      point_valid,
    output logic                      point_stall,
    input  logic signed [COORD_W-1:0] point_x,
    input  logic signed [COORD_W-1:0] point_y,
    input  logic signed [COORD_W-1:0] point_z,
    input  logic                      set_end,
    output logic                      sorted_valid,
    input  logic                      sorted_stall,
    output logic signed [COORD_W-1:0] sorted_x,
    output logic signed [COORD_W-1:0] sorted_y,
    output logic signed [COORD_W-1:0] sorted_z,
    output logic                      final_point,
    output logic                      overflowed
);

    logic signed [COORD_W-1:0] eye_x_reg;
    logic signed [COORD_W-1:0] eye_y_reg;
    logic signed [COORD_W-1:0] eye_z_reg;
    logic                      farthest_first_reg;
    reg_idx_t                  cfg_idx;
    logic                      cfg_write;

    state_t                    state_reg;
    state_t                    state_next;
    logic [CNT_W-1:0]          held_count_reg;
    logic [CNT_W-1:0]          held_count_next;
    logic                      dropped_reg;
    logic                      dropped_next;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [POINT_W-1:0]        out_point_reg;
    logic                      out_final_reg;
    logic                      out_ovf_reg;

    logic                      accept;
    logic                      busy_end;
    logic                      pop;
    key_item_t                 item;
    cell_ctrl_t                ctrl;

    logic [KEY_W-1:0]          cell_key   [MAX_POINTS];
    logic [POINT_W-1:0]        cell_point [MAX_POINTS];
    logic                      taken      [MAX_POINTS+1];

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eye_x_reg          <= '0;
            eye_y_reg          <= '0;
            eye_z_reg          <= '0;
            farthest_first_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_EYE_X:          eye_x_reg          <= pwdata[COORD_W-1:0];
                REG_EYE_Y:          eye_y_reg          <= pwdata[COORD_W-1:0];
                REG_EYE_Z:          eye_z_reg          <= pwdata[COORD_W-1:0];
                REG_FARTHEST_FIRST: farthest_first_reg <= pwdata[0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_EYE_X:          prdata = DATA_W'({1'b0, eye_x_reg});
            REG_EYE_Y:          prdata = DATA_W'({1'b0, eye_y_reg});
            REG_EYE_Z:          prdata = DATA_W'({1'b0, eye_z_reg});
            REG_FARTHEST_FIRST: prdata = DATA_W'(farthest_first_reg);
            default:            prdata = '0;
        endcase
    end

    // ---------------- key pipeline ----------------
    assign point_stall = (state_reg == ST_EMIT) || busy_end;
    assign accept      = point_valid && !point_stall;

    dsbe_key u_key
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .point_x  (point_x),
        .point_y  (point_y),
        .point_z  (point_z),
        .set_end  (set_end),
        .eye_x    (eye_x_reg),
        .eye_y    (eye_y_reg),
        .eye_z    (eye_z_reg),
        .item     (item),
        .busy_end (busy_end)
    );

    // ---------------- control ----------------
    assign pop = (state_reg == ST_EMIT) && (!out_valid_reg || !sorted_stall);

    always_comb
    begin
        state_next      = state_reg;
        held_count_next = held_count_reg;
        dropped_next    = dropped_reg;
        ctrl.insert         = 1'b0;
        ctrl.emit           = 1'b0;
        ctrl.farthest_first = farthest_first_reg;
        unique case (state_reg)
            ST_FILL:
            begin
                if (item.valid)
                begin
                    if (held_count_reg < CNT_W'(MAX_POINTS))
                    begin
                        ctrl.insert     = 1'b1;
                        held_count_next = held_count_reg + 1'b1;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (item.set_end)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (pop)
                begin
                    ctrl.emit       = 1'b1;
                    held_count_next = held_count_reg - 1'b1;
                    if (held_count_reg == CNT_W'(1))
                    begin
                        dropped_next = 1'b0;
                        state_next   = ST_FILL;
                    end
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_FILL;
            held_count_reg <= '0;
            dropped_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            held_count_reg <= held_count_next;
            dropped_reg    <= dropped_next;
        end
    end

    // ---------------- cell chain ----------------
    assign taken[0] = 1'b0;

    for (genvar i = 0; i < MAX_POINTS; i++)
    begin : g_cell
        logic               free;
        logic [KEY_W-1:0]   prev_key;
        logic [POINT_W-1:0] prev_point;
        logic [KEY_W-1:0]   next_key;
        logic [POINT_W-1:0] next_point;

        // Cells at or beyond the fill count hold nothing valid.
        assign free = CNT_W'(i) >= held_count_reg;

        if (i == 0)
        begin : g_head
            assign prev_key   = item.key;
            assign prev_point = item.point;
        end
        else
        begin : g_body
            assign prev_key   = cell_key[i-1];
            assign prev_point = cell_point[i-1];
        end

        if (i == MAX_POINTS - 1)
        begin : g_tail
            assign next_key   = cell_key[i];
            assign next_point = cell_point[i];
        end
        else
        begin : g_inner
            assign next_key   = cell_key[i+1];
            assign next_point = cell_point[i+1];
        end

        dsbe_cell u_cell
        (
            .clk        (clk),
            .ctrl       (ctrl),
            .free       (free),
            .new_key    (item.key),
            .new_point  (item.point),
            .prev_key   (prev_key),
            .prev_point (prev_point),
            .next_key   (next_key),
            .next_point (next_point),
            .taken_in   (taken[i]),
            .taken_out  (taken[i+1]),
            .key        (cell_key[i]),
            .point      (cell_point[i])
        );
    end

    // ---------------- output register ----------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!sorted_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_point_reg <= cell_point[0];
            out_final_reg <= (held_count_reg == CNT_W'(1));
            out_ovf_reg   <= dropped_reg;
        end
    end

    assign sorted_valid = out_valid_reg;
    assign sorted_x     = out_point_reg[COORD_W-1:0];
    assign sorted_y     = out_point_reg[2*COORD_W-1:COORD_W];
    assign sorted_z     = out_point_reg[3*COORD_W-1:2*COORD_W];
    assign final_point  = out_final_reg;
    assign overflowed   = out_ovf_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg <= CNT_W'(MAX_POINTS))
        else $error("fill count beyond chain length");

    a_no_insert_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> !item.valid)
        else $error("key pipeline delivered a point while the set is being sent");

    a_last_pop_refills: assert property (@(posedge clk) disable iff (!rst_n)
        pop && held_count_reg == CNT_W'(1) |=> state_reg == ST_FILL && held_count_reg == '0)
        else $error("chain not empty after the last point of a set");

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> held_count_reg != '0)
        else $error("sending a set from an empty chain");
`endif

endmodule

[tb/sv/depth_sort_points_by_eye_distance_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// depth_sort_points_by_eye_distance_tb
// Self-checking testbench of the eye-distance depth sorter. Points go in on the
// point channel. A local model keeps its own sorted store and builds the
// expected set for every set_end request. Each sorted result is compared field
// by field with the oldest expected point. Both channels idle at random, and
// the registers are set up and read back over APB between sets.
// ----------------------------------------------------------------------------
module depth_sort_points_by_eye_distance_tb;
    import dsbe_pkg::*;

    localparam int  CLK_HIGH_NS   = 6;
    localparam int  CLK_LOW_NS    = 6;
    localparam int  RESET_CYCLES  = 8;
    localparam int  MAX_GAP       = 17;
    localparam int  SETTLE_CYCLES = 8;
    localparam int  RANDOM_ITEMS  = 110;
    localparam real TIMEOUT_NS    = 2000000.0;

    typedef struct
    {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic               final_pt;
        logic               ovf;
    } sorted_point_t;

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      psel         = 1'b0;
    logic                      penable      = 1'b0;
    logic                      pwrite       = 1'b0;
    logic [ADDR_W-1:0]         paddr        = '0;
    logic [DATA_W-1:0]         pwdata       = '0;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;
    logic                      point_valid  = 1'b0;
    logic                      point_stall;
    logic signed [COORD_W-1:0] point_x      = '0;
    logic signed [COORD_W-1:0] point_y      = '0;
    logic signed [COORD_W-1:0] point_z      = '0;
    logic                      set_end      = 1'b0;
    logic                      sorted_valid;
    logic                      sorted_stall = 1'b0;
    logic signed [COORD_W-1:0] sorted_x;
    logic signed [COORD_W-1:0] sorted_y;
    logic signed [COORD_W-1:0] sorted_z;
    logic                      final_point;
    logic                      overflowed;

    // Mirror of the registers and of the sorted store.
    logic signed [COORD_W-1:0] eye_x_m = '0;
    logic signed [COORD_W-1:0] eye_y_m = '0;
    logic signed [COORD_W-1:0] eye_z_m = '0;
    logic                      far_m   = 1'b0;
    logic [COORD_W-1:0]        held_x   [MAX_POINTS];
    logic [COORD_W-1:0]        held_y   [MAX_POINTS];
    logic [COORD_W-1:0]        held_z   [MAX_POINTS];
    logic [KEY_W-1:0]          held_key [MAX_POINTS];
    int                        held_n    = 0;
    logic                      held_drop = 1'b0;

    sorted_point_t sorted_expected[$];
    int            mismatch_count = 0;
    int            hold_left      = 0;
    bit            idle_points    = 1'b1;
    bit            idle_sorted    = 1'b1;

    depth_sort_points_by_eye_distance i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .point_valid  (point_valid),
        .point_stall  (point_stall),
        .point_x      (point_x),
        .point_y      (point_y),
        .point_z      (point_z),
        .set_end      (set_end),
        .sorted_valid (sorted_valid),
        .sorted_stall (sorted_stall),
        .sorted_x     (sorted_x),
        .sorted_y     (sorted_y),
        .sorted_z     (sorted_z),
        .final_point  (final_point),
        .overflowed   (overflowed)
    );

    always
    begin
        #(CLK_LOW_NS) clk = 1'b1;
        #(CLK_HIGH_NS) clk = 1'b0;
    end

    function automatic logic [KEY_W-1:0] eye_distance_sq(
        logic signed [COORD_W-1:0] x,
        logic signed [COORD_W-1:0] y,
        logic signed [COORD_W-1:0] z);
        longint dx;
        longint dy;
        longint dz;
        dx = longint'(x) - longint'(eye_x_m);
        dy = longint'(y) - longint'(eye_y_m);
        dz = longint'(z) - longint'(eye_z_m);
        return KEY_W'(dx * dx + dy * dy + dz * dz);
    endfunction

    // Stable insertion: a new point goes after every held point of equal
    // distance. A set_end request releases the whole store in order.
    function automatic void sort_into_store(
        logic [COORD_W-1:0] x,
        logic [COORD_W-1:0] y,
        logic [COORD_W-1:0] z,
        logic               last);
        logic [KEY_W-1:0] key;
        int               pos;
        int               i;
        sorted_point_t    pt;
        if (held_n < MAX_POINTS)
        begin
            key = eye_distance_sq(x, y, z);
            pos = held_n;
            for (i = 0; i < held_n && pos == held_n; i++)
            begin
                if (far_m ? (held_key[i] < key) : (held_key[i] > key))
                    pos = i;
            end
            for (i = held_n; i > pos; i--)
            begin
                held_x[i]   = held_x[i-1];
                held_y[i]   = held_y[i-1];
                held_z[i]   = held_z[i-1];
                held_key[i] = held_key[i-1];
            end
            held_x[pos]   = x;
            held_y[pos]   = y;
            held_z[pos]   = z;
            held_key[pos] = key;
            held_n++;
        end
        else
        begin
            held_drop = 1'b1;
        end
        if (last)
        begin
            for (i = 0; i < held_n; i++)
            begin
                pt.x        = held_x[i];
                pt.y        = held_y[i];
                pt.z        = held_z[i];
                pt.final_pt = (i == held_n - 1);
                pt.ovf      = held_drop;
                sorted_expected.push_back(pt);
            end
            held_n    = 0;
            held_drop = 1'b0;
        end
    endfunction

    function automatic void compare_field(string name, logic [COORD_W-1:0] want,
                                          logic [COORD_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord(logic [COORD_W-1:0] centre);
        logic [COORD_W-1:0] v;
        case ($urandom_range(0, 3))
            0, 1:
                v = COORD_W'($urandom);
            2:
                v = centre + COORD_W'($urandom_range(0, 6)) - COORD_W'(3);
            default:
                case ($urandom_range(0, 4))
                    0:       v = 16'h8000;
                    1:       v = 16'h7FFF;
                    2:       v = 16'h0000;
                    3:       v = 16'h0001;
                    default: v = 16'hFFFF;
                endcase
        endcase
        return v;
    endfunction

    // Sorted channel: check every accepted result and hold stall for a
    // random number of cycles after it.
    always @(posedge clk)
    begin
        sorted_point_t want;
        if (rst_n)
        begin
            if (sorted_valid && !sorted_stall)
            begin
                if (sorted_expected.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h %h %h",
                             $time, sorted_x, sorted_y, sorted_z);
                    mismatch_count++;
                end
                else
                begin
                    want = sorted_expected.pop_front();
                    compare_field("sorted_x", want.x, sorted_x);
                    compare_field("sorted_y", want.y, sorted_y);
                    compare_field("sorted_z", want.z, sorted_z);
                    compare_field("final_point", COORD_W'(want.final_pt),
                                  COORD_W'(final_point));
                    compare_field("overflowed", COORD_W'(want.ovf), COORD_W'(overflowed));
                end
                hold_left = idle_sorted ? $urandom_range(0, MAX_GAP) : 0;
            end
            else if (hold_left != 0)
            begin
                hold_left--;
            end
            sorted_stall <= (hold_left != 0);
        end
    end

    // Sends one point request and leaves valid high, so that a following
    // request with no gap goes out on the next cycle.
    task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input logic [COORD_W-1:0] z, input logic last);
        int gap;
        gap = idle_points ? $urandom_range(0, MAX_GAP) : 0;
        if (gap != 0)
        begin
            point_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        point_valid <= 1'b1;
        point_x     <= x;
        point_y     <= y;
        point_z     <= z;
        set_end     <= last;
        @(posedge clk);
        while (point_stall)
            @(posedge clk);
        sort_into_store(x, y, z, last);
    endtask

    task automatic wait_sorted_drain();
        point_valid <= 1'b0;
        while (sorted_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes one register, then reads it back.
    task automatic write_register(input reg_idx_t idx, input logic [COORD_W-1:0] value);
        logic [DATA_W-1:0] data;
        logic [DATA_W-1:0] mask;
        data       = $urandom;
        data[15:0] = value;
        mask       = (idx == REG_FARTHEST_FIRST) ? 32'h1 : 32'hFFFF;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            REG_EYE_X:          eye_x_m = value;
            REG_EYE_Y:          eye_y_m = value;
            REG_EYE_Z:          eye_z_m = value;
            REG_FARTHEST_FIRST: far_m   = value[0];
            default:            ;
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if ((prdata & mask) !== (data & mask))
        begin
            $display("%0t: register %0d readback mismatch, expected %h, actual %h",
                     $time, idx, data & mask, prdata & mask);
            mismatch_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure_sort(input logic [COORD_W-1:0] ex, input logic [COORD_W-1:0] ey,
                                  input logic [COORD_W-1:0] ez, input logic ff);
        logic [COORD_W-1:0] ff_word;
        ff_word    = COORD_W'($urandom);
        ff_word[0] = ff;
        write_register(REG_EYE_X, ex);
        write_register(REG_EYE_Y, ey);
        write_register(REG_EYE_Z, ez);
        write_register(REG_FARTHEST_FIRST, ff_word);
    endtask

    task automatic test_register_access();
        configure_sort(16'h8000, 16'h7FFF, 16'h0000, 1'b1);
        configure_sort(16'h7FFF, 16'h8000, 16'hFFFF, 1'b0);
    endtask

    // Equal distances must come out in arrival order in both directions.
    task automatic test_tie_order();
        int pass;
        for (pass = 0; pass < 2; pass++)
        begin
            configure_sort(16'h0000, 16'h0000, 16'h0000, pass == 1);
            send_point(16'h0001, 16'h0000, 16'h0000, 1'b0);
            send_point(16'h0000, 16'hFFFF, 16'h0000, 1'b0);
            send_point(16'h0002, 16'h0000, 16'h0000, 1'b0);
            send_point(16'h0000, 16'h0000, 16'h0001, 1'b0);
            send_point(16'hFFFF, 16'h0000, 16'h0000, 1'b1);
            wait_sorted_drain();
        end
    endtask

    // Eye and points at opposite corners give the largest possible key.
    task automatic test_coordinate_extremes();
        configure_sort(16'h8000, 16'h8000, 16'h8000, 1'b1);
        send_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
        send_point(16'h8000, 16'h8000, 16'h8000, 1'b0);
        send_point(16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_point(16'h7FFF, 16'h8000, 16'h0000, 1'b1);
        wait_sorted_drain();
        configure_sort(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
        send_point(16'h8000, 16'h8000, 16'h8000, 1'b0);
        send_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
        send_point(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        wait_sorted_drain();
    endtask

    // Sets of a single point, back to back with no idling.
    task automatic test_single_point_sets();
        idle_points = 1'b0;
        idle_sorted = 1'b0;
        send_point(16'h1234, 16'hABCD, 16'h0F0F, 1'b1);
        send_point(16'h8001, 16'h7FFE, 16'h5555, 1'b1);
        wait_sorted_drain();
        idle_points = 1'b1;
        idle_sorted = 1'b1;
    endtask

    // Random sets, mostly small, with one set beyond capacity so that the
    // set_end point itself is dropped. The registers change before every third set.
    task automatic test_random_sets();
        int items;
        int set_no;
        int size;
        int j;
        bit big_done;
        bit ff;
        items    = 0;
        set_no   = 0;
        big_done = 1'b0;
        while (items < RANDOM_ITEMS)
        begin
            if (set_no % 3 == 0)
            begin
                wait_sorted_drain();
                ff = ($urandom_range(0, 1) != 0);
                configure_sort(pick_coord(16'h0000), pick_coord(16'h0000),
                               pick_coord(16'h0000), ff);
            end
            idle_points = ($urandom_range(0, 3) != 0);
            idle_sorted = ($urandom_range(0, 3) != 0);
            if (!big_done && items >= 30)
            begin
                size     = MAX_POINTS + $urandom_range(1, 3);
                big_done = 1'b1;
            end
            else
            begin
                size = $urandom_range(1, 10);
            end
            for (j = 0; j < size; j++)
            begin
                send_point(pick_coord(eye_x_m), pick_coord(eye_y_m), pick_coord(eye_z_m),
                           j == size - 1);
            end
            items += size;
            set_no++;
        end
        wait_sorted_drain();
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_register_access();
        test_tie_order();
        test_coordinate_extremes();
        test_single_point_sets();
        test_random_sets();
        wait_sorted_drain();
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[filelist.f]
src/dsbe_pkg.sv
src/dsbe_key.sv
src/dsbe_cell.sv
src/depth_sort_points_by_eye_distance.sv
tb/sv/depth_sort_points_by_eye_distance_tb.sv
